### rtl/idp_pkg.sv
package idp_pkg;

	typedef enum logic [4:0] {
		PH_Y1 = 5'd0, PH_Y2 = 5'd1, PH_Y3 = 5'd2, PH_Y4 = 5'd3,
		PH_DASH1 = 5'd4, PH_M1 = 5'd5, PH_M2 = 5'd6, PH_DASH2 = 5'd7,
		PH_D1 = 5'd8, PH_D2 = 5'd9, PH_DATE_DONE = 5'd10,
		PH_H1 = 5'd11, PH_H2 = 5'd12, PH_COLON1 = 5'd13,
		PH_MI1 = 5'd14, PH_MI2 = 5'd15, PH_COLON2 = 5'd16,
		PH_S1 = 5'd17, PH_S2 = 5'd18, PH_TIME_DONE = 5'd19,
		PH_FRAC1 = 5'd20, PH_FRACN = 5'd21, PH_ZULU = 5'd22,
		PH_ZH1 = 5'd23, PH_ZH2 = 5'd24, PH_ZCOLON = 5'd25,
		PH_ZM1 = 5'd26, PH_ZM2 = 5'd27, PH_ZONE_DONE = 5'd28,
		PH_DEAD = 5'd29
	} phase_t;

	localparam logic [2:0] FMT_DATE = 3'd0;
	localparam logic [2:0] FMT_TIME = 3'd1;
	localparam logic [2:0] FMT_DATETIME = 3'd2;
	localparam logic [2:0] FMT_DATE_TZ = 3'd3;
	localparam logic [2:0] FMT_TIME_TZ = 3'd4;
	localparam logic [2:0] FMT_DATETIME_TZ = 3'd5;

	localparam logic [7:0] CH_T = 8'h54;
	localparam logic [7:0] CH_ZU = 8'h5A;
	localparam logic [7:0] CH_ZL = 8'h7A;
	localparam logic [7:0] CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_DOT = 8'h2E;
	localparam logic [7:0] CH_0 = 8'h30;
	localparam logic [7:0] CH_9 = 8'h39;

	// accumulated string, handed from scanner to finisher
	typedef struct packed {
		logic [2:0]  fmt;
		logic        err;
		logic        acc_ok;
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
		logic [13:0] frac;
		logic [2:0]  frac_cnt;
		logic        zsign;
		logic [4:0]  zhour;
		logic [5:0]  zminute;
	} scan_t;

	function automatic logic is_time_fmt(input logic [2:0] f);
		return (f == FMT_TIME) || (f == FMT_TIME_TZ);
	endfunction

	function automatic logic is_dt_fmt(input logic [2:0] f);
		return (f == FMT_DATETIME) || (f == FMT_DATETIME_TZ);
	endfunction

	function automatic logic [4:0] days_in(input logic [13:0] y, input logic [3:0] m);
		logic leap;
		logic [26:0] qp;
		logic [7:0] q;
		logic [13:0] r100;
		logic [4:0] r;
		// century by reciprocal multiply; divisible by 400 when the century is by 4
		qp = 27'(y) * 27'd5243;
		q = 8'(qp >> 19);
		r100 = 14'(y - 14'(q) * 14'd100);
		leap = (y[1:0] == 2'b00) && ((r100 != 14'd0) || (q[1:0] == 2'b00));
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
			4'd2: r = leap ? 5'd29 : 5'd28;
			default: r = 5'd0;
		endcase
		return r;
	endfunction

endpackage

### rtl/idp_scanner.sv
module idp_scanner import idp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic [7:0]  ch,
	input  logic [2:0]  mode,
	input  logic        first,
	input  logic        last,
	output scan_t       scan
);

	phase_t      phase_q;
	logic [2:0]  fmt_q;
	logic        err_q;
	logic [13:0] year_q, frac_q;
	logic [3:0]  month_q;
	logic [4:0]  day_q, hour_q, zh_q;
	logic [5:0]  min_q, sec_q, zm_q;
	logic [2:0]  fcnt_q;
	logic        zs_q;

	// working copy after the optional restart on first
	phase_t      p;
	logic [2:0]  f;
	logic        e;
	logic [13:0] y, fr;
	logic [3:0]  mo;
	logic [4:0]  dy, hh, zh;
	logic [5:0]  mi, se, zm;
	logic [2:0]  fc;
	logic        zs;

	phase_t      np;
	logic        ne;
	logic [13:0] ny, nfr;
	logic [3:0]  nmo;
	logic [4:0]  ndy, nhh, nzh;
	logic [5:0]  nmi, nse, nzm;
	logic [2:0]  nfc;
	logic        nzs;

	logic        dig;
	logic [3:0]  d;
	logic [6:0]  two;
	logic        acc_ok;

	always_comb begin
		f = first ? mode : fmt_q;
		if (first) begin
			p = is_time_fmt(mode) ? PH_H1 : PH_Y1;
			e = (mode > FMT_DATETIME_TZ);
			y = '0; mo = '0; dy = '0; hh = '0; mi = '0; se = '0;
			fr = '0; fc = '0; zs = 1'b0; zh = '0; zm = '0;
		end else begin
			p = phase_q; e = err_q;
			y = year_q; mo = month_q; dy = day_q; hh = hour_q; mi = min_q; se = sec_q;
			fr = frac_q; fc = fcnt_q; zs = zs_q; zh = zh_q; zm = zm_q;
		end
		dig = (ch >= CH_0) && (ch <= CH_9);
		d = dig ? 4'(ch - CH_0) : 4'd0;
		np = p; ne = e;
		ny = y; nmo = mo; ndy = dy; nhh = hh; nmi = mi; nse = se;
		nfr = fr; nfc = fc; nzs = zs; nzh = zh; nzm = zm;
		two = 7'd0;
		if (!e) begin
			unique case (p)
				PH_Y1, PH_Y2, PH_Y3, PH_Y4, PH_M1, PH_M2, PH_D1, PH_D2, PH_H1, PH_H2,
				PH_MI1, PH_MI2, PH_S1, PH_S2, PH_ZH1, PH_ZH2, PH_ZM1, PH_ZM2: begin
					if (!dig) begin
						ne = 1'b1;
					end else begin
						np = phase_t'(p + 5'd1);
						case (p)
							PH_Y1, PH_Y2, PH_Y3, PH_Y4: ny = 14'(y * 14'd10 + 14'(d));
							PH_M1: nmo = d;
							PH_M2: begin
								two = 7'(mo * 7'd10 + 7'(d));
								if (two < 7'd1 || two > 7'd12) ne = 1'b1;
								else nmo = two[3:0];
							end
							PH_D1: ndy = 5'(d);
							PH_D2: begin
								two = 7'(dy * 7'd10 + 7'(d));
								if (two < 7'd1 || two > 7'd31) ne = 1'b1;
								else begin
									ndy = two[4:0];
									if (y < 14'd1 || two[4:0] > days_in(y, mo)) ne = 1'b1;
								end
								if (y < 14'd1) ne = 1'b1;
							end
							PH_H1: nhh = 5'(d);
							PH_H2: begin
								two = 7'(hh * 7'd10 + 7'(d));
								if (two > 7'd24) ne = 1'b1; else nhh = two[4:0];
							end
							PH_MI1: nmi = 6'(d);
							PH_MI2: begin
								two = 7'(mi * 7'd10 + 7'(d));
								if (two > 7'd59) ne = 1'b1; else nmi = two[5:0];
							end
							PH_S1: nse = 6'(d);
							PH_S2: begin
								two = 7'(se * 7'd10 + 7'(d));
								if (two > 7'd59) ne = 1'b1;
								else begin
									nse = two[5:0];
									if (hh == 5'd24 && (mi != 6'd0 || two != 7'd0)) ne = 1'b1;
								end
								if (two > 7'd59 && hh == 5'd24 && mi != 6'd0) ne = 1'b1;
							end
							PH_ZH1: nzh = 5'(d);
							PH_ZH2: begin
								two = 7'(zh * 7'd10 + 7'(d));
								if (two > 7'd23) ne = 1'b1; else nzh = two[4:0];
							end
							PH_ZM1: nzm = 6'(d);
							default: begin
								two = 7'(zm * 7'd10 + 7'(d));
								if (two > 7'd59) ne = 1'b1; else nzm = two[5:0];
							end
						endcase
						if (ne) np = p;
					end
				end
				PH_DASH1, PH_DASH2: begin
					if (ch == CH_MINUS) np = phase_t'(p + 5'd1); else ne = 1'b1;
				end
				PH_COLON1, PH_COLON2, PH_ZCOLON: begin
					if (ch == CH_COLON) np = phase_t'(p + 5'd1); else ne = 1'b1;
				end
				PH_DATE_DONE, PH_TIME_DONE, PH_FRACN: begin
					if (p == PH_DATE_DONE && is_dt_fmt(f)) begin
						if (ch == CH_T) np = PH_H1; else ne = 1'b1;
					end else if (p == PH_TIME_DONE && ch == CH_DOT) begin
						np = PH_FRAC1;
					end else if (p == PH_FRACN && dig) begin
						if (fc < 3'd4) begin
							nfr = 14'(fr * 14'd10 + 14'(d));
							nfc = 3'(fc + 3'd1);
						end
					end else if (ch == CH_ZU || ch == CH_ZL) begin
						np = PH_ZULU;
					end else if (ch == CH_PLUS) begin
						nzs = 1'b0; np = PH_ZH1;
					end else if (ch == CH_MINUS) begin
						nzs = 1'b1; np = PH_ZH1;
					end else begin
						ne = 1'b1;
					end
				end
				PH_FRAC1: begin
					if (!dig) ne = 1'b1;
					else begin
						nfr = 14'(d); nfc = 3'd1; np = PH_FRACN;
					end
				end
				default: ne = 1'b1;
			endcase
		end
		if (np == PH_ZULU || np == PH_ZONE_DONE) acc_ok = 1'b1;
		else if (f == FMT_DATE || f == FMT_DATE_TZ) acc_ok = (np == PH_DATE_DONE);
		else acc_ok = (np == PH_TIME_DONE) || (np == PH_FRACN);
	end

	always_comb begin
		scan.fmt = f; scan.err = ne; scan.acc_ok = acc_ok;
		scan.year = ny; scan.month = nmo; scan.day = ndy; scan.hour = nhh;
		scan.minute = nmi; scan.second = nse; scan.frac = nfr; scan.frac_cnt = nfc;
		scan.zsign = nzs; scan.zhour = nzh; scan.zminute = nzm;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_Y1; fmt_q <= FMT_DATE; err_q <= 1'b0;
			year_q <= '0; month_q <= '0; day_q <= '0; hour_q <= '0; min_q <= '0;
			sec_q <= '0; frac_q <= '0; fcnt_q <= '0; zs_q <= 1'b0; zh_q <= '0; zm_q <= '0;
		end else if (en) begin
			fmt_q <= f;
			if (last) begin
				phase_q <= is_time_fmt(f) ? PH_H1 : PH_Y1;
				err_q <= (f > FMT_DATETIME_TZ);
				year_q <= '0; month_q <= '0; day_q <= '0; hour_q <= '0; min_q <= '0;
				sec_q <= '0; frac_q <= '0; fcnt_q <= '0; zs_q <= 1'b0; zh_q <= '0; zm_q <= '0;
			end else begin
				phase_q <= np; err_q <= ne;
				year_q <= ny; month_q <= nmo; day_q <= ndy; hour_q <= nhh; min_q <= nmi;
				sec_q <= nse; frac_q <= nfr; fcnt_q <= nfc; zs_q <= nzs; zh_q <= nzh;
				zm_q <= nzm;
			end
		end
	end

endmodule

### rtl/idp_finish.sv
module idp_finish import idp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  scan_t       scan,
	output logic        valid,
	input  logic        ready,
	output logic        status,
	output logic [13:0] year,
	output logic [3:0]  month,
	output logic [4:0]  day,
	output logic [4:0]  hour,
	output logic [5:0]  minute,
	output logic [5:0]  second,
	output logic [9:0]  millisecond,
	output logic signed [11:0] offset_minutes
);

	// stage 1: round fraction, build offset in minutes
	logic        v_s1;
	scan_t       sc_s1;
	logic [9:0]  ms_s1;
	logic        msc_s1;
	logic [10:0] offm_s1;

	logic [13:0] prod;
	logic [14:0] rnd;
	logic [29:0] rq;
	logic [10:0] rms;
	logic [10:0] offm;

	always_comb begin
		case (scan.frac_cnt)
			3'd1: prod = 14'(scan.frac * 14'd1000);
			3'd2: prod = 14'(scan.frac * 14'd100);
			3'd3: prod = 14'(scan.frac * 14'd10);
			3'd4: prod = scan.frac;
			default: prod = 14'd0;
		endcase
		rnd = 15'(prod) + 15'd5;
		// divide by ten via reciprocal
		rq = 30'(rnd) * 30'd52429;
		rms = 11'(rq >> 19);
		offm = 11'(scan.zhour * 11'd60 + 11'(scan.zminute));
	end

	logic s2_free;
	assign in_ready = !v_s1 || s2_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (in_ready) v_s1 <= in_valid;
	end
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			sc_s1 <= scan;
			msc_s1 <= (rms >= 11'd1000);
			ms_s1 <= (rms >= 11'd1000) ? 10'(rms - 11'd1000) : rms[9:0];
			offm_s1 <= offm;
		end
	end

	// stage 2: time in minutes of day, offset subtracted for FMT_TIME and FMT_DATETIME, then date carry
	logic        has_date, has_time, sub_off, bad, h24;
	logic [5:0]  s_adj;
	logic        c_min;
	logic signed [12:0] tmin;
	logic        dlt_p, dlt_n;
	logic [10:0] tm;
	logic [21:0] hprod;
	logic [4:0]  tm_h;
	logic [5:0]  tm_m;
	logic [13:0] y;
	logic [3:0]  mo;
	logic [4:0]  dy, dim, dimp;
	logic [3:0]  mprev;
	logic [13:0] yprev;
	logic signed [11:0] off_s;

	always_comb begin
		has_date = !is_time_fmt(sc_s1.fmt);
		has_time = (sc_s1.fmt != FMT_DATE) && (sc_s1.fmt != FMT_DATE_TZ);
		sub_off = (sc_s1.fmt == FMT_TIME) || (sc_s1.fmt == FMT_DATETIME);
		off_s = sc_s1.zsign ? -$signed({1'b0, offm_s1}) : $signed({1'b0, offm_s1});
		h24 = (sc_s1.hour == 5'd24);
		bad = sc_s1.err || !sc_s1.acc_ok || (sc_s1.fmt > FMT_DATETIME_TZ);
		if (has_time && h24 && (ms_s1 != 10'd0 || msc_s1 || offm_s1 != 11'd0)) bad = 1'b1;
		c_min = msc_s1 && (sc_s1.second == 6'd59);
		s_adj = msc_s1 ? (c_min ? 6'd0 : 6'(sc_s1.second + 6'd1)) : sc_s1.second;
		tmin = $signed({2'b0, 11'(sc_s1.hour * 11'd60 + 11'(sc_s1.minute))})
			+ $signed({12'b0, c_min});
		if (sub_off) tmin = tmin - 13'(off_s);
		dlt_n = tmin < 0;
		dlt_p = tmin >= 13'sd1440;
		if (dlt_n) tm = 11'(tmin + 13'sd1440);
		else if (dlt_p) tm = 11'(tmin - 13'sd1440);
		else tm = 11'(tmin);
		// hour by reciprocal of sixty, minute as remainder
		hprod = 22'(tm) * 22'd2185;
		tm_h = 5'(hprod >> 17);
		tm_m = 6'(tm - 11'(tm_h) * 11'd60);
		y = sc_s1.year; mo = sc_s1.month; dy = sc_s1.day;
		dim = days_in(y, mo);
		mprev = (mo > 4'd1) ? 4'(mo - 4'd1) : 4'd12;
		yprev = (mo > 4'd1) ? y : 14'(y - 14'd1);
		dimp = days_in(yprev, mprev);
		if (has_time && !h24 && has_date && dlt_p) begin
			if (dy < dim) dy = 5'(dy + 5'd1);
			else begin
				dy = 5'd1;
				if (mo < 4'd12) mo = 4'(mo + 4'd1);
				else begin
					mo = 4'd1; y = 14'(y + 14'd1);
				end
				if (y > 14'd9999) bad = 1'b1;
			end
		end else if (has_time && !h24 && has_date && dlt_n) begin
			if (dy > 5'd1) dy = 5'(dy - 5'd1);
			else begin
				mo = mprev; y = yprev; dy = dimp;
				if (yprev < 14'd1) bad = 1'b1;
			end
		end
	end

	assign s2_free = !valid || ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid <= 1'b0;
		else if (s2_free) valid <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (s2_free && v_s1) begin
			status <= bad;
			year <= (bad || !has_date) ? 14'd0 : y;
			month <= (bad || !has_date) ? 4'd0 : mo;
			day <= (bad || !has_date) ? 5'd0 : dy;
			if (bad || !has_time) begin
				hour <= '0; minute <= '0; second <= '0; millisecond <= '0;
			end else if (h24) begin
				hour <= 5'd24; minute <= '0; second <= '0; millisecond <= '0;
			end else begin
				hour <= tm_h;
				minute <= tm_m;
				second <= s_adj;
				millisecond <= ms_s1;
			end
			offset_minutes <= (bad || sc_s1.fmt < FMT_DATE_TZ) ? 12'sd0 : off_s;
		end
	end

endmodule

### rtl/iso8601_datetime_parser.sv
// ISO 8601 date/time parser.
// Input channel: one character beat per cycle on ch with valid/ready, while in_ready is high. first
// marks the opening character and samples mode; last marks the closing one.
// Output channel: one result beat per string, raised for the beat that had
// last set: status (0 good, 1 error) and the decoded fields, all zero on error.
// The scanner's next state and the fraction rounding are registered in the
// first stage, the offset and date carry in the result register.
// Throughput: one character per cycle sustained while in_ready is high.
// A stalled receiver holds the result; characters keep being taken until the
// first stage also holds a finished string, then ready falls.
// Reset clears the scanner to the start of a date string with date mode
// latched and empties the result pipeline.
module iso8601_datetime_parser import idp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  ch,
	input  logic [2:0]  mode,
	input  logic        first,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        status,
	output logic [13:0] year,
	output logic [3:0]  month,
	output logic [4:0]  day,
	output logic [4:0]  hour,
	output logic [5:0]  minute,
	output logic [5:0]  second,
	output logic [9:0]  millisecond,
	output logic signed [11:0] offset_minutes
);

	scan_t scan;
	logic  fin_ready;

	assign in_ready = fin_ready;

	idp_scanner u_scan (
		.clk(clk), .arst_n(arst_n), .en(in_valid && fin_ready),
		.ch(ch), .mode(mode), .first(first), .last(last), .scan(scan)
	);

	idp_finish u_fin (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid && last), .in_ready(fin_ready), .scan(scan),
		.valid(out_valid), .ready(out_ready), .status(status),
		.year(year), .month(month), .day(day), .hour(hour), .minute(minute),
		.second(second), .millisecond(millisecond), .offset_minutes(offset_minutes)
	);

endmodule
